FILE: rtl/csc_pkg.sv
package csc_pkg;

    // Width of the disc fields on the input side.
    localparam int DISC_W = 8;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_NOSOL = 2'd2,
        ST_OVF   = 2'd3
    } status_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_DIV_R    = 4'd2,
        OP_GET_R    = 4'd3,
        OP_DIV_T    = 4'd4,
        OP_GET_TM   = 4'd5,
        OP_DIV_P    = 4'd6,
        OP_GET_PM   = 4'd7,
        OP_STEP     = 4'd8,
        OP_GCD_STEP = 4'd9,
        OP_DIV_Q    = 4'd10,
        OP_MUL      = 4'd11,
        OP_COMMIT   = 4'd12,
        OP_EMIT     = 4'd13
    } dp_op_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        dp_op_t  op;
        logic    set_err;
        status_t err_code;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_ok;
        logic bad_input;
        logic div_done;
        logic hit;
        logic last_k;
        logic step_ovf;
        logic gcd_done;
        logic mul_ovf;
        logic last;
        logic out_busy;
    } dp_stat_t;

endpackage

FILE: rtl/csc_ctrl.sv
module csc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               disc_valid,
    output logic               disc_stall,
    input  csc_pkg::dp_stat_t  stat,
    output csc_pkg::dp_cmd_t   cmd
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_CHECK   = 14'b00000000000010,
        S_WAIT_R  = 14'b00000000000100,
        S_START_T = 14'b00000000001000,
        S_WAIT_T  = 14'b00000000010000,
        S_START_P = 14'b00000000100000,
        S_WAIT_P  = 14'b00000001000000,
        S_SIEVE   = 14'b00000010000000,
        S_GCD     = 14'b00000100000000,
        S_WAIT_Q  = 14'b00001000000000,
        S_MUL     = 14'b00010000000000,
        S_COMMIT  = 14'b00100000000000,
        S_FINISH  = 14'b01000000000000,
        S_SPARE   = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Only the idle state takes a new disc.
    assign disc_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = csc_pkg::OP_NONE;
        cmd.set_err  = 1'b0;
        cmd.err_code = csc_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (disc_valid)
                begin
                    cmd.op     = csc_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.acc_ok)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.bad_input)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = csc_pkg::ST_BAD;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.op     = csc_pkg::OP_DIV_R;
                    state_next = S_WAIT_R;
                end
            end
            S_WAIT_R:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = csc_pkg::OP_GET_R;
                    state_next = S_START_T;
                end
            end
            S_START_T:
            begin
                cmd.op     = csc_pkg::OP_DIV_T;
                state_next = S_WAIT_T;
            end
            S_WAIT_T:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = csc_pkg::OP_GET_TM;
                    state_next = S_START_P;
                end
            end
            S_START_P:
            begin
                cmd.op     = csc_pkg::OP_DIV_P;
                state_next = S_WAIT_P;
            end
            S_WAIT_P:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = csc_pkg::OP_GET_PM;
                    state_next = S_SIEVE;
                end
            end
            S_SIEVE:
            begin
                priority if (stat.hit)
                begin
                    state_next = S_GCD;
                end
                else if (stat.last_k)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = csc_pkg::ST_NOSOL;
                    state_next   = S_FINISH;
                end
                else if (stat.step_ovf)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = csc_pkg::ST_OVF;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.op = csc_pkg::OP_STEP;
                end
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.op     = csc_pkg::OP_DIV_Q;
                    state_next = S_WAIT_Q;
                end
                else
                begin
                    cmd.op = csc_pkg::OP_GCD_STEP;
                end
            end
            S_WAIT_Q:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = csc_pkg::OP_MUL;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // The product register settles in this cycle.
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.mul_ovf)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = csc_pkg::ST_OVF;
                end
                else
                begin
                    cmd.op = csc_pkg::OP_COMMIT;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (!stat.out_busy)
                begin
                    cmd.op     = csc_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/csc_dp.sv
module csc_dp #(
    parameter int MODULUS_BITS = 8,
    parameter int TIME_BITS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  csc_pkg::dp_cmd_t   cmd,
    output csc_pkg::dp_stat_t  stat,
    input  logic [7:0]         disc_delay,
    input  logic [7:0]         positions,
    input  logic [7:0]         start_position,
    input  logic               last,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [63:0]        first_time,
    output logic [63:0]        common_period,
    output logic [1:0]         status
);

    localparam int DW = csc_pkg::DISC_W;
    localparam logic [DW-1:0] MMASK = DW'((32'd1 << MODULUS_BITS) - 32'd1);
    localparam int CW = $clog2(TIME_BITS + 1);
    localparam int PW = TIME_BITS + DW;

    // Disc registers.
    logic [DW-1:0]        delay_reg;
    logic [DW-1:0]        m_reg;
    logic [DW-1:0]        a_reg;
    logic                 last_reg;
    logic [DW-1:0]        r_reg;
    logic [DW-1:0]        tm_reg;
    logic [DW-1:0]        pm_reg;
    logic [DW-1:0]        k_reg;
    logic [DW-1:0]        gx_reg;
    logic [DW-1:0]        gy_reg;
    logic [PW-1:0]        prod_reg;

    // Accumulated pair and status.
    logic [TIME_BITS-1:0] t_reg;
    logic [TIME_BITS-1:0] p_reg;
    csc_pkg::status_t     st_reg;

    // Shared restoring divider.
    logic [TIME_BITS-1:0] div_n_reg;
    logic [DW-1:0]        div_d_reg;
    logic [DW-1:0]        div_rem_reg;
    logic [CW-1:0]        div_cnt_reg;
    logic                 div_busy_reg;
    logic                 div_done_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [63:0]          out_time_reg;
    logic [63:0]          out_period_reg;
    csc_pkg::status_t     out_status_reg;

    logic                 div_start;
    logic [TIME_BITS-1:0] div_dividend;
    logic [DW-1:0]        div_divisor;
    logic [DW:0]          div_sh;
    logic [DW:0]          div_sub;
    logic                 div_ge;
    logic [DW:0]          sum_ad;
    logic [DW:0]          tm_sum;
    logic [DW-1:0]        tm_next;
    logic [TIME_BITS:0]   step_sum;

    // Divider operand selection.
    always_comb
    begin
        sum_ad    = {1'b0, a_reg} + {1'b0, delay_reg};
        div_start = (cmd.op == csc_pkg::OP_DIV_R) || (cmd.op == csc_pkg::OP_DIV_T)
                 || (cmd.op == csc_pkg::OP_DIV_P) || (cmd.op == csc_pkg::OP_DIV_Q);
        priority case (cmd.op)
            csc_pkg::OP_DIV_R: div_dividend = TIME_BITS'(sum_ad);
            csc_pkg::OP_DIV_T: div_dividend = t_reg;
            default:           div_dividend = p_reg;
        endcase
        div_divisor = (cmd.op == csc_pkg::OP_DIV_Q) ? gx_reg : m_reg;
        div_sh      = {div_rem_reg, div_n_reg[TIME_BITS-1]};
        div_sub     = div_sh - {1'b0, div_d_reg};
        div_ge      = (div_sh >= {1'b0, div_d_reg});
    end

    // Sieve step arithmetic: the time advances by the period, its residue by pm.
    always_comb
    begin
        tm_sum   = {1'b0, tm_reg} + {1'b0, pm_reg};
        tm_next  = (tm_sum >= {1'b0, m_reg}) ? DW'(tm_sum - {1'b0, m_reg}) : tm_sum[DW-1:0];
        step_sum = {1'b0, t_reg} + {1'b0, p_reg};
    end

    // Status toward the controller.
    always_comb
    begin
        stat.acc_ok    = (st_reg == csc_pkg::ST_OK);
        stat.bad_input = (m_reg == '0) || (a_reg >= m_reg);
        stat.div_done  = div_done_reg;
        stat.hit       = (tm_reg == r_reg);
        stat.last_k    = (k_reg == DW'(m_reg - 1'b1));
        stat.step_ovf  = step_sum[TIME_BITS];
        stat.gcd_done  = (gy_reg == '0);
        stat.mul_ovf   = (prod_reg[PW-1:TIME_BITS] != '0);
        stat.last      = last_reg;
        stat.out_busy  = out_valid_reg && result_stall;
    end

    // Divider data path: one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_n_reg   <= div_dividend;
            div_d_reg   <= div_divisor;
            div_rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            div_n_reg   <= {div_n_reg[TIME_BITS-2:0], div_ge};
            div_rem_reg <= div_ge ? div_sub[DW-1:0] : div_sh[DW-1:0];
        end
    end

    // Divider control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg  <= '0;
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
        end
        else
        begin
            div_done_reg <= div_busy_reg && (div_cnt_reg == CW'(1));
            if (div_start)
            begin
                div_cnt_reg  <= CW'(TIME_BITS);
                div_busy_reg <= 1'b1;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == CW'(1))
                begin
                    div_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Per-disc working registers.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            csc_pkg::OP_LOAD:
            begin
                delay_reg <= disc_delay;
                m_reg     <= positions & MMASK;
                a_reg     <= start_position & MMASK;
                last_reg  <= last;
            end
            csc_pkg::OP_GET_R:
            begin
                r_reg <= (div_rem_reg == '0) ? '0 : DW'(m_reg - div_rem_reg);
            end
            csc_pkg::OP_GET_TM:
            begin
                tm_reg <= div_rem_reg;
            end
            csc_pkg::OP_GET_PM:
            begin
                pm_reg <= div_rem_reg;
                gx_reg <= m_reg;
                gy_reg <= div_rem_reg;
                k_reg  <= '0;
            end
            csc_pkg::OP_STEP:
            begin
                tm_reg <= tm_next;
                k_reg  <= k_reg + 1'b1;
            end
            csc_pkg::OP_GCD_STEP:
            begin
                // Subtractive Euclid on the two narrow operands.
                if (gx_reg >= gy_reg)
                begin
                    gx_reg <= gx_reg - gy_reg;
                end
                else
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= gx_reg;
                end
            end
            csc_pkg::OP_MUL:
            begin
                prod_reg <= PW'(div_n_reg) * PW'(m_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Accumulator and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg         <= '0;
            p_reg         <= TIME_BITS'(1);
            st_reg        <= csc_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result wins over the drain of the old one.
            if (cmd.op == csc_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.set_err)
            begin
                st_reg <= cmd.err_code;
            end
            else if (cmd.op == csc_pkg::OP_EMIT)
            begin
                st_reg <= csc_pkg::ST_OK;
            end
            unique case (cmd.op)
                csc_pkg::OP_STEP:
                begin
                    t_reg <= step_sum[TIME_BITS-1:0];
                end
                csc_pkg::OP_COMMIT:
                begin
                    p_reg <= prod_reg[TIME_BITS-1:0];
                end
                csc_pkg::OP_EMIT:
                begin
                    t_reg <= '0;
                    p_reg <= TIME_BITS'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result payload, zeroed on any error status.
    always_ff @(posedge clk)
    begin
        if (cmd.op == csc_pkg::OP_EMIT)
        begin
            out_status_reg <= st_reg;
            if (st_reg == csc_pkg::ST_OK)
            begin
                out_time_reg   <= 64'(t_reg);
                out_period_reg <= 64'(p_reg);
            end
            else
            begin
                out_time_reg   <= '0;
                out_period_reg <= '0;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign first_time    = out_time_reg;
    assign common_period = out_period_reg;
    assign status        = out_status_reg;

endmodule

FILE: rtl/congruence_sieve_combiner.sv
// Channel   Handshake                    Payload
// disc      disc_valid / disc_stall      disc_delay, positions, start_position, last
// result    result_valid / result_stall  first_time, common_period, status
//
// Per disc, the shared one-bit-per-cycle divider runs up to four times, the sieve steps
// at most once per position of the disc, and the gcd takes one subtractive step per
// pass until its second operand is zero.
// Reset clears the accumulator to time 0, period 1, status ok; no clearing pass.
// A waiting result does not block the next disc; only the next result on a last
// disc waits for the result register to drain.
module congruence_sieve_combiner #(
    parameter int MODULUS_BITS = 8,
    parameter int TIME_BITS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        disc_valid,
    output logic        disc_stall,
    input  logic [7:0]  disc_delay,
    input  logic [7:0]  positions,
    input  logic [7:0]  start_position,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] first_time,
    output logic [63:0] common_period,
    output logic [1:0]  status
);

    csc_pkg::dp_cmd_t  cmd;
    csc_pkg::dp_stat_t stat;

    // Sequencer.
    csc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .disc_valid (disc_valid),
        .disc_stall (disc_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Arithmetic and result register.
    csc_dp #(
        .MODULUS_BITS (MODULUS_BITS),
        .TIME_BITS    (TIME_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .disc_delay     (disc_delay),
        .positions      (positions),
        .start_position (start_position),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .first_time     (first_time),
        .common_period  (common_period),
        .status         (status)
    );

    // A disc transfer is always followed by disc_stall high.
    assert property (@(posedge clk) disable iff (!rst_n)
        disc_valid && !disc_stall |=> disc_stall)
        else $error("disc accepted on back-to-back cycles");

    // An error result carries zero time and period.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != csc_pkg::ST_OK) |-> (first_time == '0) && (common_period == '0))
        else $error("error result with nonzero payload");

    // A good result has a nonzero period.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == csc_pkg::ST_OK) |-> (common_period != '0))
        else $error("ok result with zero period");

endmodule
